>>> sv/rhc_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter package
// Shared widths, constants, codes and structures of the converter pipeline.
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int CHAN_W = 8;
    localparam int HUE_W  = 13;
    localparam int PCT_W  = 11;
    localparam int SUM_W  = 9;
    localparam int DIFF_W = 9;
    localparam int HNUM_W = 23;

    localparam int CHAN_MAX    = 255;
    localparam int HUE_FULL    = 5760;
    localparam int HUE_SEXTANT = 960;
    localparam int PCT_FULL    = 1600;

    // Lightness is floor((320 * sum + 51) / 102), done by a reciprocal multiply.
    localparam int LIGHT_X_W     = 18;
    localparam int LIGHT_MUL     = 320;
    localparam int LIGHT_BIAS    = 51;
    localparam int LIGHT_RECIP_W = 18;
    localparam int LIGHT_RECIP   = 164483;
    localparam int LIGHT_SHIFT   = 24;

    localparam int DIV_NUM_W     = 22;
    localparam int DIV_DEN_W     = 9;
    localparam int DIV_LANES     = 2;
    localparam int LANE_HUE      = 0;
    localparam int LANE_SAT      = 1;
    localparam int DIV_STEPS_DEF = 4;

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } max_sel_t;

    typedef struct packed {
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_op_t;

    typedef struct packed {
        logic              gray;
        logic [PCT_W-1:0]  lightness;
        logic [CHAN_W-1:0] alpha;
    } rhc_side_t;

    typedef struct packed {
        div_op_t [DIV_LANES-1:0] op;
        rhc_side_t               side;
    } rhc_prep_t;

endpackage

>>> sv/rhc_rgba_if.sv
// ----------------------------------------------------------------------------
// RGBA pixel channel
// Valid/ready channel that carries one RGBA pixel per transfer.
// ----------------------------------------------------------------------------
interface rhc_rgba_if;
    import rhc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;

    modport source (output valid, output red, output green, output blue, output alpha,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    output ready);
endinterface

>>> sv/rhc_hsla_if.sv
// ----------------------------------------------------------------------------
// HSLA pixel channel
// Valid/ready channel that carries one HSLA result per transfer.
// ----------------------------------------------------------------------------
interface rhc_hsla_if;
    import rhc_pkg::*;

    logic              valid;
    logic              ready;
    logic [HUE_W-1:0]  hue;
    logic [PCT_W-1:0]  saturation;
    logic [PCT_W-1:0]  lightness;
    logic [CHAN_W-1:0] alpha_out;

    modport source (output valid, output hue, output saturation, output lightness,
                    output alpha_out, input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    input alpha_out, output ready);
endinterface

>>> sv/rhc_prep.sv
// ----------------------------------------------------------------------------
// Converter front end
// Two pipeline stages: channel extremes, then divider operands and lightness.
// ----------------------------------------------------------------------------
module rhc_prep (
    input  logic               clk,
    input  logic               rst_n,
    rhc_rgba_if.sink           rgba,
    output logic               op_valid,
    input  logic               op_ready,
    output rhc_pkg::rhc_prep_t op_data
);
    import rhc_pkg::*;

    logic                     a_ready;
    logic                     b_ready;
    logic                     a_valid_reg;
    logic [SUM_W-1:0]         a_sum_reg;
    logic [SUM_W-1:0]         a_sum_next;
    logic [CHAN_W-1:0]        a_delta_reg;
    logic [CHAN_W-1:0]        a_delta_next;
    logic signed [DIFF_W-1:0] a_n_reg;
    logic signed [DIFF_W-1:0] a_n_next;
    max_sel_t                 a_sel_reg;
    max_sel_t                 a_sel_next;
    logic [LIGHT_X_W-1:0]     a_x_reg;
    logic [LIGHT_X_W-1:0]     a_x_next;
    logic [CHAN_W-1:0]        a_alpha_reg;
    logic [CHAN_W-1:0]        mx;
    logic [CHAN_W-1:0]        mn;

    logic                     b_valid_reg;
    rhc_prep_t                b_data_reg;
    rhc_prep_t                b_data_next;
    logic [SUM_W-1:0]         den_full;
    logic signed [HNUM_W-1:0] off_term;
    logic signed [HNUM_W-1:0] hnum_raw;
    logic signed [HNUM_W-1:0] hnum_wrap;
    logic [LIGHT_X_W+LIGHT_RECIP_W-1:0] light_prod;

    assign b_ready    = !b_valid_reg || op_ready;
    assign a_ready    = !a_valid_reg || b_ready;
    assign rgba.ready = a_ready;

    always_comb
    begin
        if (rgba.red >= rgba.green && rgba.red >= rgba.blue)
        begin
            a_sel_next = MAX_RED;
            mx         = rgba.red;
            a_n_next   = $signed({1'b0, rgba.green}) - $signed({1'b0, rgba.blue});
        end
        else if (rgba.green >= rgba.blue)
        begin
            a_sel_next = MAX_GREEN;
            mx         = rgba.green;
            a_n_next   = $signed({1'b0, rgba.blue}) - $signed({1'b0, rgba.red});
        end
        else
        begin
            a_sel_next = MAX_BLUE;
            mx         = rgba.blue;
            a_n_next   = $signed({1'b0, rgba.red}) - $signed({1'b0, rgba.green});
        end
        mn = rgba.red;
        if (rgba.green < mn)
        begin
            mn = rgba.green;
        end
        if (rgba.blue < mn)
        begin
            mn = rgba.blue;
        end
        a_sum_next   = SUM_W'(mx) + SUM_W'(mn);
        a_delta_next = mx - mn;
        a_x_next     = LIGHT_X_W'(a_sum_next) * LIGHT_X_W'(LIGHT_MUL)
                     + LIGHT_X_W'(LIGHT_BIAS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= rgba.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && rgba.valid)
        begin
            a_sum_reg   <= a_sum_next;
            a_delta_reg <= a_delta_next;
            a_n_reg     <= a_n_next;
            a_sel_reg   <= a_sel_next;
            a_x_reg     <= a_x_next;
            a_alpha_reg <= rgba.alpha;
        end
    end

    always_comb
    begin
        den_full = (a_sum_reg < SUM_W'(CHAN_MAX)) ? a_sum_reg
                                                  : SUM_W'(2 * CHAN_MAX) - a_sum_reg;
        unique case (a_sel_reg)
            MAX_RED:   off_term = '0;
            MAX_GREEN: off_term = $signed(HNUM_W'(a_delta_reg) * HNUM_W'(2 * HUE_SEXTANT));
            MAX_BLUE:  off_term = $signed(HNUM_W'(a_delta_reg) * HNUM_W'(4 * HUE_SEXTANT));
            default:   off_term = '0;
        endcase
        hnum_raw  = HNUM_W'(a_n_reg) * HNUM_W'(HUE_SEXTANT) + off_term;
        hnum_wrap = hnum_raw[HNUM_W-1]
                  ? hnum_raw + $signed(HNUM_W'(a_delta_reg) * HNUM_W'(HUE_FULL))
                  : hnum_raw;
        light_prod = (LIGHT_X_W+LIGHT_RECIP_W)'(a_x_reg)
                   * (LIGHT_X_W+LIGHT_RECIP_W)'(LIGHT_RECIP);

        b_data_next.op[LANE_HUE].num = DIV_NUM_W'({hnum_wrap, 1'b0})
                                     + DIV_NUM_W'(a_delta_reg);
        b_data_next.op[LANE_HUE].den = DIV_DEN_W'({a_delta_reg, 1'b0});
        b_data_next.op[LANE_SAT].num = DIV_NUM_W'(a_delta_reg) * DIV_NUM_W'(2 * PCT_FULL)
                                     + DIV_NUM_W'(den_full);
        b_data_next.op[LANE_SAT].den = DIV_DEN_W'({den_full, 1'b0});
        b_data_next.side.gray        = (a_delta_reg == '0);
        b_data_next.side.lightness   = light_prod[LIGHT_SHIFT +: PCT_W];
        b_data_next.side.alpha       = a_alpha_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign op_valid = b_valid_reg;
    assign op_data  = b_data_reg;

endmodule

>>> sv/rhc_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Two lanes (hue and saturation) in lockstep, a fixed number of quotient
// bits resolved in each register stage.
// ----------------------------------------------------------------------------
module rhc_div #(
    parameter int STEPS = rhc_pkg::DIV_STEPS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          op_valid,
    output logic                                          op_ready,
    input  rhc_pkg::rhc_prep_t                            op_data,
    output logic                                          quo_valid,
    input  logic                                          quo_ready,
    output logic [rhc_pkg::DIV_LANES-1:0][rhc_pkg::HUE_W-1:0] quo,
    output rhc_pkg::rhc_side_t                            side
);
    import rhc_pkg::*;

    localparam int STAGES = (HUE_W + STEPS - 1) / STEPS;
    localparam int QUO_W  = STAGES * STEPS;
    localparam int WORK_W = DIV_DEN_W + QUO_W;

    typedef logic [DIV_LANES-1:0][WORK_W-1:0]    work_t;
    typedef logic [DIV_LANES-1:0][DIV_DEN_W-1:0] dens_t;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   stage_ready;
    work_t             work_reg [STAGES];
    work_t             work_next [STAGES];
    work_t             work_src [STAGES];
    dens_t             den_reg [STAGES];
    dens_t             den_src [STAGES];
    rhc_side_t         side_reg [STAGES];
    rhc_side_t         side_src [STAGES];
    logic              valid_src [STAGES];

    function automatic logic [WORK_W-1:0] div_steps(input logic [WORK_W-1:0]    w_in,
                                                    input logic [DIV_DEN_W-1:0] den);
        logic [WORK_W-1:0]  w;
        logic [DIV_DEN_W:0] trial;
        w = w_in;
        for (int i = 0; i < STEPS; i++)
        begin
            trial = {w[WORK_W-1 -: DIV_DEN_W], w[QUO_W-1]};
            if (trial >= {1'b0, den})
            begin
                w = {DIV_DEN_W'(trial - {1'b0, den}), w[QUO_W-2:0], 1'b1};
            end
            else
            begin
                w = {trial[DIV_DEN_W-1:0], w[QUO_W-2:0], 1'b0};
            end
        end
        return w;
    endfunction

    assign stage_ready[STAGES] = quo_ready;
    assign op_ready            = stage_ready[0];

    always_comb
    begin
        for (int l = 0; l < DIV_LANES; l++)
        begin
            work_src[0][l] = WORK_W'(op_data.op[l].num);
            den_src[0][l]  = op_data.op[l].den;
        end
        side_src[0]  = op_data.side;
        valid_src[0] = op_valid;
    end

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        if (s > 0)
        begin : g_link
            assign work_src[s]  = work_reg[s-1];
            assign den_src[s]   = den_reg[s-1];
            assign side_src[s]  = side_reg[s-1];
            assign valid_src[s] = valid_reg[s-1];
        end

        assign stage_ready[s] = !valid_reg[s] || stage_ready[s+1];

        always_comb
        begin
            for (int l = 0; l < DIV_LANES; l++)
            begin
                work_next[s][l] = div_steps(work_src[s][l], den_src[s][l]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (stage_ready[s])
            begin
                valid_reg[s] <= valid_src[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[s] && valid_src[s])
            begin
                work_reg[s] <= work_next[s];
                den_reg[s]  <= den_src[s];
                side_reg[s] <= side_src[s];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < DIV_LANES; l++)
        begin
            quo[l] = work_reg[STAGES-1][l][HUE_W-1:0];
        end
    end

    assign quo_valid = valid_reg[STAGES-1];
    assign side      = side_reg[STAGES-1];

endmodule

>>> sv/rgb_to_hsl_converter_unit.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter
// Converts RGBA pixels with 8-bit channels to fixed-point HSLA.
//
//   Channel  Role    Transfer content
//   rgba     sink    red, green, blue, alpha (8 bits each)
//   hsla     source  hue (1/16 degree), saturation and lightness
//                    (1/16 percent), alpha_out
//
// One pixel is taken per clock while the output is not stalled. Pixels pass
// the front-end stages, the divider stages and the output register in turn,
// with four quotient bits per divider stage by default. Reset clears all
// valid bits; no clearing pass follows. Stages advance independently, so a
// stalled output holds its result while empty stages upstream keep filling.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter_unit #(
    parameter int DIV_STEPS = rhc_pkg::DIV_STEPS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rhc_rgba_if.sink   rgba,
    rhc_hsla_if.source hsla
);
    import rhc_pkg::*;

    logic                                op_valid;
    logic                                op_ready;
    rhc_prep_t                           op_data;
    logic                                quo_valid;
    logic                                quo_ready;
    logic [DIV_LANES-1:0][HUE_W-1:0]     quo;
    rhc_side_t                           side;

    logic              out_valid_reg;
    logic [HUE_W-1:0]  hue_reg;
    logic [HUE_W-1:0]  hue_next;
    logic [PCT_W-1:0]  sat_reg;
    logic [PCT_W-1:0]  sat_next;
    logic [PCT_W-1:0]  light_reg;
    logic [CHAN_W-1:0] alpha_reg;

    rhc_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .rgba     (rgba),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op_data  (op_data)
    );

    rhc_div #(
        .STEPS (DIV_STEPS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_ready  (op_ready),
        .op_data   (op_data),
        .quo_valid (quo_valid),
        .quo_ready (quo_ready),
        .quo       (quo),
        .side      (side)
    );

    assign quo_ready = !out_valid_reg || hsla.ready;

    // A rounded hue of a full turn wraps to zero; a gray pixel has no hue.
    always_comb
    begin
        if (side.gray)
        begin
            hue_next = '0;
            sat_next = '0;
        end
        else
        begin
            hue_next = (quo[LANE_HUE] >= HUE_W'(HUE_FULL))
                     ? quo[LANE_HUE] - HUE_W'(HUE_FULL)
                     : quo[LANE_HUE];
            sat_next = quo[LANE_SAT][PCT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (quo_ready)
        begin
            out_valid_reg <= quo_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (quo_ready && quo_valid)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            light_reg <= side.lightness;
            alpha_reg <= side.alpha;
        end
    end

    assign hsla.valid      = out_valid_reg;
    assign hsla.hue        = hue_reg;
    assign hsla.saturation = sat_reg;
    assign hsla.lightness  = light_reg;
    assign hsla.alpha_out  = alpha_reg;

endmodule

>>> sv/rhc_checker.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter checker
// Watches the result channel of the converter for protocol and range slips.
// ----------------------------------------------------------------------------
module rhc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [rhc_pkg::HUE_W-1:0]  hue,
    input logic [rhc_pkg::PCT_W-1:0]  saturation,
    input logic [rhc_pkg::PCT_W-1:0]  lightness,
    input logic [rhc_pkg::CHAN_W-1:0] alpha_out
);
    import rhc_pkg::*;

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before transfer");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(hue) && $stable(saturation)
                                    && $stable(lightness) && $stable(alpha_out))
        else $error("stalled result changed");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hue < HUE_W'(HUE_FULL))
        else $error("hue not wrapped below a full turn");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> saturation <= PCT_W'(PCT_FULL) && lightness <= PCT_W'(PCT_FULL))
        else $error("saturation or lightness above full scale");

    a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturation == '0 |-> hue == '0)
        else $error("gray result carries a hue");

endmodule

bind rgb_to_hsl_converter_unit rhc_checker u_rhc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (hsla.valid),
    .out_ready  (hsla.ready),
    .hue        (hsla.hue),
    .saturation (hsla.saturation),
    .lightness  (hsla.lightness),
    .alpha_out  (hsla.alpha_out)
);

>>> tb/sv/tb_rgb_to_hsl_converter_unit.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter testbench
// Drives RGBA pixels into the converter under random source gaps and sink
// stalls, predicts each HSLA result in fixed point, and compares every
// transfer on the output field by field, in order. A short list of corner
// pixels comes first, followed by about eleven hundred shaped random pixels.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsl_converter_unit;
    import rhc_pkg::*;

    localparam int PIPE_LATENCY = 3 + (HUE_W + DIV_STEPS_DEF - 1) / DIV_STEPS_DEF;
    localparam int RANDOM_PIXELS = 1100;
    localparam int STALL_LIMIT  = 4000;
    localparam int IDLE_PERCENT = 37;
    localparam int CORNER_ROWS  = 23;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [PCT_W-1:0]  sat;
        logic [PCT_W-1:0]  light;
        logic [CHAN_W-1:0] alpha;
    } hsla_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        bit                golden;
        logic [HUE_W-1:0]  hue;
        logic [PCT_W-1:0]  sat;
        logic [PCT_W-1:0]  light;
    } corner_row_t;

    logic clk;
    logic rst_n;

    rhc_rgba_if rgba_ch ();
    rhc_hsla_if hsla_ch ();

    rgb_to_hsl_converter_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .rgba  (rgba_ch),
        .hsla  (hsla_ch)
    );

    hsla_t hsl_expected [$];
    bit    steady;
    bit    row_golden;
    hsla_t row_hsla;
    int    errors;
    int    stall_cycles;
    int    pixels_in;
    int    results_out;
    int    gray_pixels;
    bit    accepted;
    hsla_t oldest;

    // Rows marked golden carry a result that can be read off directly.
    corner_row_t corner_pixels [0:CORNER_ROWS-1] = '{
        '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 13'd0,    11'd0,    11'd0},
        '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 13'd0,    11'd0,    11'd1600},
        '{8'd255, 8'd0,   8'd0,   8'hA5,  1'b1, 13'd0,    11'd1600, 11'd800},
        '{8'd0,   8'd255, 8'd0,   8'h5A,  1'b1, 13'd1920, 11'd1600, 11'd800},
        '{8'd0,   8'd0,   8'd255, 8'd255, 1'b1, 13'd3840, 11'd1600, 11'd800},
        '{8'd128, 8'd128, 8'd128, 8'd0,   1'b0, 13'd0,    11'd0,    11'd0},
        '{8'd1,   8'd1,   8'd1,   8'd1,   1'b0, 13'd0,    11'd0,    11'd0},
        '{8'd254, 8'd254, 8'd254, 8'd254, 1'b0, 13'd0,    11'd0,    11'd0},
        '{8'd255, 8'd255, 8'd0,   8'd17,  1'b0, 13'd0,    11'd0,    11'd0},
        '{8'd0,   8'd255, 8'd255, 8'd34,  1'b0, 13'd0,    11'd0,    11'd0},
        '{8'd255, 8'd0,   8'd255, 8'd51,  1'b0, 13'd0,    11'd0,    11'd0},
        '{8'd255, 8'd0,   8'd1,   8'd68,  1'b0, 13'd0,    11'd0,    11'd0},
        '{8'd255, 8'd1,   8'd0,   8'd85,  1'b0, 13'd0,    11'd0,    11'd0},
        '{8'd254, 8'd0,   8'd0,   8'd102, 1'b0, 13'd0,    11'd0,    11'd0},
        '{8'd128, 8'd127, 8'd127, 8'd119, 1'b0, 13'd0,    11'd0,    11'd0},
        '{8'd127, 8'd127, 8'd126, 8'd136, 1'b0, 13'd0,    11'd0,    11'd0},
        '{8'd255, 8'd254, 8'd254, 8'd153, 1'b0, 13'd0,    11'd0,    11'd0},
        '{8'd1,   8'd0,   8'd0,   8'd170, 1'b0, 13'd0,    11'd0,    11'd0},
        '{8'd0,   8'd1,   8'd0,   8'd187, 1'b0, 13'd0,    11'd0,    11'd0},
        '{8'd0,   8'd0,   8'd1,   8'd204, 1'b0, 13'd0,    11'd0,    11'd0},
        '{8'd100, 8'd200, 8'd50,  8'd221, 1'b0, 13'd0,    11'd0,    11'd0},
        '{8'd30,  8'd60,  8'd240, 8'd238, 1'b0, 13'd0,    11'd0,    11'd0},
        '{8'd170, 8'd85,  8'd255, 8'h81,  1'b0, 13'd0,    11'd0,    11'd0}
    };

    function automatic int round_up_div(input int num, input int den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic hsla_t convert_pixel(input logic [CHAN_W-1:0] r8,
                                            input logic [CHAN_W-1:0] g8,
                                            input logic [CHAN_W-1:0] b8,
                                            input logic [CHAN_W-1:0] a8);
        int r, g, b, hi, lo, sum, diff, den, n, off, hnum, h;
        hsla_t res;
        r = r8;
        g = g8;
        b = b8;
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        sum  = hi + lo;
        diff = hi - lo;
        res.alpha = a8;
        res.hue   = '0;
        res.sat   = '0;
        res.light = PCT_W'(round_up_div(sum * PCT_FULL, 2 * CHAN_MAX));
        if (diff != 0)
        begin
            den = (sum < CHAN_MAX) ? sum : 2 * CHAN_MAX - sum;
            res.sat = PCT_W'(round_up_div(diff * PCT_FULL, den));
            if (r == hi)
            begin
                n   = g - b;
                off = 0;
            end
            else if (g == hi)
            begin
                n   = b - r;
                off = 2 * HUE_SEXTANT;
            end
            else
            begin
                n   = r - g;
                off = 4 * HUE_SEXTANT;
            end
            hnum = HUE_SEXTANT * n + off * diff;
            if (hnum < 0)
                hnum += HUE_FULL * diff;
            h = round_up_div(hnum, diff);
            if (h >= HUE_FULL)
                h -= HUE_FULL;
            res.hue = HUE_W'(h);
        end
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("ERROR: %s is %0d, expected %0d (result %0d)", what, got, want,
                 results_out);
        errors++;
    endtask

    // Shapes random pixels toward grays, ties, extremes, small deltas and
    // the lightness midpoint where the saturation denominator switches.
    task automatic pick_pixel(output logic [CHAN_W-1:0] r, output logic [CHAN_W-1:0] g,
                              output logic [CHAN_W-1:0] b, output logic [CHAN_W-1:0] a);
        int c [3];
        int mode, hi, lo, k, j, t;
        mode = $urandom_range(9);
        for (k = 0; k < 3; k++)
            c[k] = $urandom_range(255);
        case (mode)
            4:
            begin
                c[1] = c[0];
                c[2] = c[0];
            end
            5:
            begin
                c[1] = c[0];
                c[2] = $urandom_range(c[0]);
            end
            6:
            begin
                for (k = 0; k < 3; k++)
                begin
                    t = $urandom_range(3);
                    c[k] = (t == 0) ? 0 : (t == 1) ? 1 : (t == 2) ? 254 : 255;
                end
            end
            7:
            begin
                c[1] = c[0] + $urandom_range(4) - 2;
                c[2] = c[0] + $urandom_range(4) - 2;
                for (k = 1; k < 3; k++)
                begin
                    if (c[k] < 0) c[k] = 0;
                    if (c[k] > 255) c[k] = 255;
                end
            end
            8:
            begin
                hi = $urandom_range(255, 128);
                lo = 254 - hi + $urandom_range(2);
                if (lo > hi) lo = hi;
                c[0] = hi;
                c[1] = lo;
                c[2] = $urandom_range(hi, lo);
            end
            default:
            begin
            end
        endcase
        for (k = 2; k > 0; k--)
        begin
            j = $urandom_range(k);
            t = c[k];
            c[k] = c[j];
            c[j] = t;
        end
        r = CHAN_W'(c[0]);
        g = CHAN_W'(c[1]);
        b = CHAN_W'(c[2]);
        a = CHAN_W'($urandom);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] a,
                              input bit golden, input hsla_t want);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            rgba_ch.valid <= 1'b0;
            rgba_ch.red   <= CHAN_W'($urandom);
            rgba_ch.green <= CHAN_W'($urandom);
            rgba_ch.blue  <= CHAN_W'($urandom);
            rgba_ch.alpha <= CHAN_W'($urandom);
            @(negedge clk);
        end
        rgba_ch.valid <= 1'b1;
        rgba_ch.red   <= r;
        rgba_ch.green <= g;
        rgba_ch.blue  <= b;
        rgba_ch.alpha <= a;
        row_golden = golden;
        row_hsla   = want;
        do
            @(posedge clk);
        while (!rgba_ch.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        rgba_ch.valid <= 1'b0;
        while (hsl_expected.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        hsla_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            hsla_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            accepted = 1'b0;
            if (hsla_ch.valid && hsla_ch.ready)
            begin
                accepted = 1'b1;
                results_out++;
                if (hsl_expected.size() == 0)
                begin
                    flag_mismatch("hue of a result with no pending pixel",
                                  hsla_ch.hue, 0);
                end
                else
                begin
                    oldest = hsl_expected.pop_front();
                    if (hsla_ch.hue !== oldest.hue)
                        flag_mismatch("hue", hsla_ch.hue, oldest.hue);
                    if (hsla_ch.saturation !== oldest.sat)
                        flag_mismatch("saturation", hsla_ch.saturation, oldest.sat);
                    if (hsla_ch.lightness !== oldest.light)
                        flag_mismatch("lightness", hsla_ch.lightness, oldest.light);
                    if (hsla_ch.alpha_out !== oldest.alpha)
                        flag_mismatch("alpha_out", hsla_ch.alpha_out, oldest.alpha);
                end
            end
            if (rgba_ch.valid && rgba_ch.ready)
            begin
                accepted = 1'b1;
                pixels_in++;
                if (rgba_ch.red == rgba_ch.green && rgba_ch.green == rgba_ch.blue)
                    gray_pixels++;
                if (row_golden)
                    hsl_expected.push_back(row_hsla);
                else
                    hsl_expected.push_back(convert_pixel(rgba_ch.red, rgba_ch.green,
                                                         rgba_ch.blue, rgba_ch.alpha));
            end
            stall_cycles = accepted ? 0 : stall_cycles + 1;
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("ERROR: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, hsl_expected.size());
        $display("FAIL rgb_to_hsl_converter_unit");
        $finish;
    end

    initial
    begin
        logic [CHAN_W-1:0] r, g, b, a;
        hsla_t want;
        int i;
        errors        = 0;
        stall_cycles  = 0;
        pixels_in     = 0;
        results_out   = 0;
        gray_pixels   = 0;
        steady        = 1'b0;
        row_golden    = 1'b0;
        row_hsla      = '0;
        rst_n         = 1'b0;
        rgba_ch.valid = 1'b0;
        rgba_ch.red   = '0;
        rgba_ch.green = '0;
        rgba_ch.blue  = '0;
        rgba_ch.alpha = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (i = 0; i < CORNER_ROWS; i++)
        begin
            want.hue   = corner_pixels[i].hue;
            want.sat   = corner_pixels[i].sat;
            want.light = corner_pixels[i].light;
            want.alpha = corner_pixels[i].alpha;
            send_pixel(corner_pixels[i].red, corner_pixels[i].green,
                       corner_pixels[i].blue, corner_pixels[i].alpha,
                       corner_pixels[i].golden, want);
        end
        wait_drained();

        for (i = 0; i < RANDOM_PIXELS; i++)
        begin
            steady = (i >= 300 && i < 500);
            if (i == 700)
                wait_drained();
            pick_pixel(r, g, b, a);
            send_pixel(r, g, b, a, 1'b0, '0);
        end
        steady = 1'b0;
        wait_drained();
        repeat (PIPE_LATENCY + 20) @(posedge clk);

        $display("Sent %0d pixels (%0d corner cases, %0d gray), checked %0d results.",
                 pixels_in, CORNER_ROWS, gray_pixels, results_out);
        $display("Source gaps and sink stalls were random, with one stall-free stretch.");
        if (errors == 0 && hsl_expected.size() == 0)
            $display("PASS rgb_to_hsl_converter_unit");
        else
            $display("FAIL rgb_to_hsl_converter_unit");
        $finish;
    end

endmodule

>>> rgb_to_hsl_converter_unit.f
sv/rhc_pkg.sv
sv/rhc_rgba_if.sv
sv/rhc_hsla_if.sv
sv/rhc_prep.sv
sv/rhc_div.sv
sv/rgb_to_hsl_converter_unit.sv
sv/rhc_checker.sv
tb/sv/tb_rgb_to_hsl_converter_unit.sv
